[rtl/region_map_appender_macros.svh]
// assertion macros shared by the region map appender rtl
// no dependencies; included by modules that carry concurrent checks
`ifndef REGION_MAP_APPENDER_MACROS_SVH
`define REGION_MAP_APPENDER_MACROS_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define RMA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// next-cycle implication, checked on the rising clock edge outside reset
`define RMA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

[rtl/rma_pkg.sv]
// types and constants for the region map appender
// no dependencies; imported by rma_csr, rma_engine and region_map_appender
`timescale 1ns / 1ps

package rma_pkg;

   // result status codes
   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BAD_ADDR = 3'd1,
      ST_BAD_LEN  = 3'd2,
      ST_BAD_ATTR = 3'd3,
      ST_FULL     = 3'd4,
      ST_NO_ROOM  = 3'd5
   } status_type;

   // register index, taken from paddr[2]
   typedef enum logic {
      REG_ATTR_MASK = 1'b0,
      REG_GAP_ATTR  = 1'b1
   } reg_idx_type;

   localparam logic [7:0] ATTR_MASK_RESET = 8'd31;
   localparam logic [7:0] GAP_ATTR_RESET  = 8'd0;

   // configuration seen by the engine
   typedef struct packed {
      logic [7:0] attr_mask;
      logic [7:0] gap_attr;
   } cfg_type;

   // registered request handed to the engine
   typedef struct packed {
      logic        valid;
      logic [31:0] base_addr;
      logic [31:0] region_len;
      logic [7:0]  attr_bits;
   } req_type;

endpackage

[rtl/region_map_appender.sv]
// top level of the region map appender: request register, csr block and engine
// depends on rma_pkg, rma_csr, rma_engine and region_map_appender_macros.svh
`timescale 1ns / 1ps

//  channel   | ports                              | handshake
//  ----------+------------------------------------+-----------------------------------
//  request   | start, busy, req_*                 | taken when start high, busy low
//  result    | rsp_valid, rsp_*                   | one-cycle strobe, cannot be held
//  config    | psel, penable, pwrite, paddr, ...  | apb write on access cycle, pready=1
//
// a request is registered at the edge it is taken and its result is strobed
// in the cycle after, and outside reset a new request can follow every cycle
// the rate is set by the single check path between the request and result registers
// busy follows reset only; after reset the table is empty and both csrs hold defaults
// results cannot be stalled, so nothing in the block ever waits on the receiver

`include "region_map_appender_macros.svh"

module region_map_appender #(
   parameter int REGION_SLOTS  = 8,
   parameter int GRANULE_SHIFT = 12
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_base_addr,
   input  logic [31:0] req_region_len,
   input  logic [7:0]  req_attr_bits,
   // result channel
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_regions_used,
   output logic        rsp_gap_added,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import rma_pkg::*;

   // request register in front of the engine
   req_type req_ff;
   req_type req_in;
   cfg_type cfg;
   logic    accept;

   // no request is taken while reset is held
   assign busy   = reset;
   assign accept = start && !busy;

   always_comb begin
      req_in.valid      = accept;
      req_in.base_addr  = req_base_addr;
      req_in.region_len = req_region_len;
      req_in.attr_bits  = req_attr_bits;
   end

   // valid bit is control, cleared on reset; payload captured only when a request is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         req_ff.valid <= 1'b0;
      end else begin
         req_ff.valid <= req_in.valid;
      end
      if (accept) begin
         req_ff.base_addr  <= req_in.base_addr;
         req_ff.region_len <= req_in.region_len;
         req_ff.attr_bits  <= req_in.attr_bits;
      end
   end

   rma_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rma_engine #(
      .REGION_SLOTS  (REGION_SLOTS),
      .GRANULE_SHIFT (GRANULE_SHIFT)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ff),
      .cfg              (cfg),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_regions_used (rsp_regions_used),
      .rsp_gap_added    (rsp_gap_added)
   );

   // every taken request reaches the engine on the next edge
   `RMA_ASSERT_NEXT(a_req_reg, clock, reset, accept, req_ff.valid)
   // the request register holds nothing that was not taken
   `RMA_ASSERT_NEXT(a_no_phantom, clock, reset, !accept, !req_ff.valid)
   // a result strobe always traces back to a taken request, through the request and result registers
   `RMA_ASSERT_NOW(a_rsp_origin, clock, reset, rsp_valid, $past(accept, 2))

endmodule

[rtl/rma_csr.sv]
// apb-style configuration registers of the region map appender
// depends on rma_pkg
`timescale 1ns / 1ps

module rma_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output rma_pkg::cfg_type cfg
);
   import rma_pkg::*;

   logic [7:0]  attr_mask_ff;
   logic [7:0]  attr_mask_in;
   logic [7:0]  gap_attr_ff;
   logic [7:0]  gap_attr_in;
   logic        wr_en;
   reg_idx_type idx;

   assign idx    = reg_idx_type'(paddr[2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      attr_mask_in = attr_mask_ff;
      gap_attr_in  = gap_attr_ff;
      if (wr_en) begin
         unique case (idx)
            REG_ATTR_MASK: attr_mask_in = pwdata[7:0];
            REG_GAP_ATTR:  gap_attr_in  = pwdata[7:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_mask_ff <= ATTR_MASK_RESET;
         gap_attr_ff  <= GAP_ATTR_RESET;
      end else begin
         attr_mask_ff <= attr_mask_in;
         gap_attr_ff  <= gap_attr_in;
      end
   end

   always_comb begin
      unique case (idx)
         REG_ATTR_MASK: prdata = {24'd0, attr_mask_ff};
         REG_GAP_ATTR:  prdata = {24'd0, gap_attr_ff};
      endcase
   end

   assign cfg.attr_mask = attr_mask_ff;
   assign cfg.gap_attr  = gap_attr_ff;

endmodule

[rtl/rma_engine.sv]
// request checks, table state and result register of the region map appender
// depends on rma_pkg and region_map_appender_macros.svh
`timescale 1ns / 1ps

`include "region_map_appender_macros.svh"

module rma_engine #(
   parameter int REGION_SLOTS  = 8,
   parameter int GRANULE_SHIFT = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  rma_pkg::req_type req,
   input  rma_pkg::cfg_type cfg,
   output logic             rsp_valid,
   output logic [2:0]       rsp_status,
   output logic [3:0]       rsp_regions_used,
   output logic             rsp_gap_added
);
   import rma_pkg::*;

   localparam int          CntW     = $clog2(REGION_SLOTS + 1);
   localparam logic [31:0] GranMask = 32'((64'd1 << GRANULE_SHIFT) - 64'd1);

   // only the newest entry is ever looked at, so its end (granule aligned) is kept
   logic [CntW-1:0] fill_cnt_ff;
   logic [CntW-1:0] fill_cnt_in;
   logic [31:0]     last_end_ff;
   logic [31:0]     last_end_in;
   logic            rsp_valid_ff;
   status_type      status_ff;
   status_type      status_in;
   logic            gap_ff;
   logic            gap_in;

   logic [31:0]     end_sum;
   logic [31:0]     cnt_ext;

   assign end_sum = req.base_addr + req.region_len;

   always_comb begin
      status_in   = ST_OK;
      gap_in      = 1'b0;
      fill_cnt_in = fill_cnt_ff;
      last_end_in = last_end_ff;
      if (req.valid) begin
         priority if ((req.base_addr & GranMask) != 32'd0) begin
            status_in = ST_BAD_ADDR;
         end else if (req.region_len == 32'd0) begin
            status_in = ST_BAD_LEN;
         end else if ((req.attr_bits & cfg.attr_mask) != req.attr_bits) begin
            status_in = ST_BAD_ATTR;
         end else if (fill_cnt_ff >= CntW'(REGION_SLOTS)) begin
            status_in = ST_FULL;
         end else if (req.base_addr < last_end_ff) begin
            status_in = ST_BAD_ADDR;
         end else if (req.base_addr > last_end_ff) begin
            if (fill_cnt_ff == CntW'(REGION_SLOTS - 1)) begin
               status_in = ST_NO_ROOM;
            end else begin
               // filler entry plus the region itself
               gap_in      = 1'b1;
               fill_cnt_in = fill_cnt_ff + CntW'(2);
               last_end_in = end_sum & ~GranMask;
            end
         end else begin
            fill_cnt_in = fill_cnt_ff + CntW'(1);
            last_end_in = end_sum & ~GranMask;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_cnt_ff  <= '0;
         last_end_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_cnt_ff  <= fill_cnt_in;
         last_end_ff  <= last_end_in;
         rsp_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      gap_ff    <= gap_in;
   end

   assign cnt_ext          = 32'(fill_cnt_ff);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_regions_used = cnt_ext[3:0];
   assign rsp_gap_added    = gap_ff;

   `RMA_ASSERT_NOW(a_cnt_bound, clock, reset, 1'b1, fill_cnt_ff <= CntW'(REGION_SLOTS))
   `RMA_ASSERT_NOW(a_gap_only_ok, clock, reset, rsp_valid_ff && gap_ff, status_ff == ST_OK)
   `RMA_ASSERT_NEXT(a_one_result, clock, reset, req.valid, rsp_valid_ff)
   `RMA_ASSERT_NOW(a_reject_keeps_state, clock, reset,
                   rsp_valid_ff && (status_ff != ST_OK), $stable(fill_cnt_ff))

endmodule
